// ===== sv/tmsb_pkg.sv =====
// Shared widths, constants and types of the trimmed-mean sample batch averager.
package tmsb_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 40;
  localparam int TRIM_W   = 35;
  localparam int SLOTS    = 3;

  // The constant divider works on 20-bit digits of the 40-bit dividend.
  localparam int CHUNK_W  = 20;
  localparam int NUM_W    = 28;
  localparam int REM_W    = 8;
  localparam int RECIP_W  = NUM_W + 1;
  localparam int PROD_W   = NUM_W + RECIP_W;

  typedef logic [SLOTS-1:0][SAMPLE_W-1:0] tmsb_slots_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    tmsb_slots_t      lo;
    tmsb_slots_t      hi;
  } tmsb_snap_t;

endpackage

// ===== sv/tmsb_accum.sv =====
// Input register, batch counter, running sum and extreme-value tracking.
module tmsb_accum #(
  parameter int BATCH_SIZE     = 28,
  parameter int WARMUP_SKIP    = 2,
  parameter int TRIM_EACH_SIDE = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tmsb_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  output logic                           snap_valid,
  input  logic                           snap_ready,
  output tmsb_pkg::tmsb_snap_t           snap
);

  localparam int CW = $clog2(BATCH_SIZE);
  localparam logic [CW-1:0] LAST_IDX = CW'(BATCH_SIZE - 1);
  localparam logic [CW-1:0] WARM_IDX = CW'(WARMUP_SKIP);

  logic                          hold_valid;
  logic [tmsb_pkg::SAMPLE_W-1:0] hold_sample;
  logic [CW-1:0]                 count;
  logic [tmsb_pkg::SUM_W-1:0]    sum;
  tmsb_pkg::tmsb_slots_t         lo;
  tmsb_pkg::tmsb_slots_t         hi;

  logic                          is_last;
  logic                          keep;
  logic                          fire;
  logic [tmsb_pkg::SUM_W-1:0]    sum_next;
  tmsb_pkg::tmsb_slots_t         lo_next;
  tmsb_pkg::tmsb_slots_t         hi_next;
  logic [tmsb_pkg::SAMPLE_W-1:0] lo_carry;
  logic [tmsb_pkg::SAMPLE_W-1:0] hi_carry;

  assign is_last      = (count == LAST_IDX);
  assign keep         = (count >= WARM_IDX);
  assign fire         = hold_valid && (!is_last || !snap_valid || snap_ready);
  assign sample_ready = !hold_valid || fire;

  // Each kept item is inserted into both sorted slot lists; a displaced value moves down.
  always_comb begin
    sum_next = sum;
    lo_next  = lo;
    hi_next  = hi;
    lo_carry = hold_sample;
    hi_carry = hold_sample;
    if (keep) begin
      sum_next = sum + {{(tmsb_pkg::SUM_W - tmsb_pkg::SAMPLE_W){1'b0}}, hold_sample};
      for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
        if (lo_carry < lo[i]) begin
          lo_next[i] = lo_carry;
          lo_carry   = lo[i];
        end
        if (hi_carry > hi[i]) begin
          hi_next[i] = hi_carry;
          hi_carry   = hi[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      count      <= '0;
      sum        <= '0;
      lo         <= '1;
      hi         <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (sample_ready) begin
        hold_valid <= sample_valid;
      end
      if (fire && is_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (fire) begin
        if (is_last) begin
          count      <= '0;
          sum        <= '0;
          lo         <= '1;
          hi         <= '0;
        end else begin
          count <= count + CW'(1);
          sum   <= sum_next;
          lo    <= lo_next;
          hi    <= hi_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      hold_sample <= sample;
    end
    if (fire && is_last) begin
      snap.sum <= sum_next;
      snap.lo  <= lo_next;
      snap.hi  <= hi_next;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= LAST_IDX)
    else $error("Batch position ran past the last item.");

  a_slots_sorted: assert property (@(posedge clk) disable iff (rst)
    lo[0] <= lo[1] && lo[1] <= lo[2] && hi[0] >= hi[1] && hi[1] >= hi[2])
    else $error("Tracked extreme values are out of order.");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && is_last |=> count == '0 && sum == '0 && snap_valid)
    else $error("Batch end did not clear state and raise a snapshot.");
`endif

endmodule

// ===== sv/tmsb_trim.sv =====
// Sum of the trimmed extremes and its subtraction from the batch total.
module tmsb_trim #(
  parameter int TRIM_EACH_SIDE = 3,
  parameter int DIVISOR        = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        snap_valid,
  output logic                        snap_ready,
  input  tmsb_pkg::tmsb_snap_t        snap,
  output logic                        diff_valid,
  input  logic                        diff_ready,
  output logic [tmsb_pkg::SUM_W-1:0]  diff
);

  localparam logic DIV_OK = (DIVISOR > 0);

  logic                        a_valid;
  logic [tmsb_pkg::SUM_W-1:0]  a_sum;
  logic [tmsb_pkg::TRIM_W-1:0] a_trim;
  logic                        a_free;
  logic                        b_free;
  logic [tmsb_pkg::TRIM_W-1:0] trim_sum;
  logic [tmsb_pkg::SUM_W-1:0]  trim_ext;
  logic [tmsb_pkg::SUM_W-1:0]  diff_next;

  assign b_free     = !diff_valid || diff_ready;
  assign a_free     = !a_valid || b_free;
  assign snap_ready = a_free;

  always_comb begin
    trim_sum = '0;
    for (int i = 0; i < TRIM_EACH_SIDE; i++) begin
      trim_sum = trim_sum
               + {{(tmsb_pkg::TRIM_W - tmsb_pkg::SAMPLE_W){1'b0}}, snap.lo[i]}
               + {{(tmsb_pkg::TRIM_W - tmsb_pkg::SAMPLE_W){1'b0}}, snap.hi[i]};
    end
  end

  assign trim_ext  = {{(tmsb_pkg::SUM_W - tmsb_pkg::TRIM_W){1'b0}}, a_trim};
  assign diff_next = (DIV_OK && trim_ext <= a_sum) ? (a_sum - trim_ext) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      diff_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= snap_valid;
      end
      if (b_free) begin
        diff_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && snap_valid) begin
      a_sum  <= snap.sum;
      a_trim <= trim_sum;
    end
    if (b_free && a_valid) begin
      diff <= diff_next;
    end
  end

endmodule

// ===== sv/tmsb_div.sv =====
// Division by the constant sample count, one 20-bit digit at a time by reciprocal.
module tmsb_div #(
  parameter int DIVISOR = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          diff_valid,
  output logic                          diff_ready,
  input  logic [tmsb_pkg::SUM_W-1:0]    diff,
  output logic                          mean_valid,
  input  logic                          mean_ready,
  output logic [tmsb_pkg::SAMPLE_W-1:0] mean
);

  localparam int DIV_USE = (DIVISOR > 0) ? DIVISOR : 1;
  localparam int SHIFT   = tmsb_pkg::NUM_W + $clog2(DIV_USE);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(DIV_USE) - 64'd1) / 64'(DIV_USE);
  localparam logic [tmsb_pkg::RECIP_W-1:0] RECIP = tmsb_pkg::RECIP_W'(RECIP_L);
  localparam logic [tmsb_pkg::REM_W-1:0]   DIV_C = tmsb_pkg::REM_W'(DIV_USE);

  logic                             s3_valid;
  logic [tmsb_pkg::PROD_W-1:0]      s3_prod;
  logic [tmsb_pkg::CHUNK_W-1:0]     s3_high;
  logic [tmsb_pkg::CHUNK_W-1:0]     s3_low;
  logic                             s4_valid;
  logic [tmsb_pkg::CHUNK_W-1:0]     s4_quot;
  logic [tmsb_pkg::REM_W-1:0]       s4_rem;
  logic [tmsb_pkg::CHUNK_W-1:0]     s4_low;
  logic                             s5_valid;
  logic [tmsb_pkg::PROD_W-1:0]      s5_prod;
  logic [tmsb_pkg::CHUNK_W-1:0]     s5_quot;

  logic                             o_free;
  logic                             s5_free;
  logic                             s4_free;
  logic                             s3_free;
  logic [tmsb_pkg::CHUNK_W-1:0]     q_high;
  logic [tmsb_pkg::NUM_W-1:0]       q_times_d;
  logic [tmsb_pkg::CHUNK_W-1:0]     rem_full;

  assign o_free     = !mean_valid || mean_ready;
  assign s5_free    = !s5_valid || o_free;
  assign s4_free    = !s4_valid || s5_free;
  assign s3_free    = !s3_valid || s4_free;
  assign diff_ready = s3_free;

  assign q_high    = s3_prod[SHIFT +: tmsb_pkg::CHUNK_W];
  assign q_times_d = {{(tmsb_pkg::NUM_W - tmsb_pkg::CHUNK_W){1'b0}}, q_high}
                   * {{(tmsb_pkg::NUM_W - tmsb_pkg::REM_W){1'b0}}, DIV_C};
  assign rem_full  = s3_high - q_times_d[tmsb_pkg::CHUNK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_valid <= diff_valid;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (s5_free) begin
        s5_valid <= s4_valid;
      end
      if (o_free) begin
        mean_valid <= s5_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && diff_valid) begin
      s3_prod <= tmsb_pkg::PROD_W'(diff[tmsb_pkg::SUM_W-1:tmsb_pkg::CHUNK_W])
               * tmsb_pkg::PROD_W'(RECIP);
      s3_high <= diff[tmsb_pkg::SUM_W-1:tmsb_pkg::CHUNK_W];
      s3_low  <= diff[tmsb_pkg::CHUNK_W-1:0];
    end
    if (s4_free && s3_valid) begin
      s4_quot <= q_high;
      s4_rem  <= rem_full[tmsb_pkg::REM_W-1:0];
      s4_low  <= s3_low;
    end
    if (s5_free && s4_valid) begin
      s5_prod <= tmsb_pkg::PROD_W'({s4_rem, s4_low}) * tmsb_pkg::PROD_W'(RECIP);
      s5_quot <= s4_quot;
    end
    if (o_free && s5_valid) begin
      mean <= {s5_quot[tmsb_pkg::SAMPLE_W-tmsb_pkg::CHUNK_W-1:0],
               s5_prod[SHIFT +: tmsb_pkg::CHUNK_W]};
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> s4_rem < DIV_C)
    else $error("Upper digit remainder is not below the divisor.");

  a_no_divisor: assert property (@(posedge clk) disable iff (rst)
    mean_valid && (DIVISOR <= 0) |-> mean == '0)
    else $error("Non-zero mean with no samples left after trimming.");

  a_s3_holds: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !s4_free |=> s3_valid && $stable(s3_prod))
    else $error("First divider stage lost an item under a stall.");
`endif

endmodule

// ===== sv/trimmed_mean_sample_batch.sv =====
// Top level of the trimmed-mean sample batch averager.
//
//   Channel  Payload         Handshake
//   sample   sample[31:0]    sample_valid / sample_ready
//   mean     mean[31:0]      mean_valid / mean_ready
//
// One sample is taken in every cycle while sample_ready is high; the running sum and
// the sorted extreme slots are updated from the registered sample when it moves on.
// The mean of a batch passes from the snapshot register through two trimming stages
// and four stages of the constant divider.
// Input stalls only while the result path is full and the last sample of a batch waits.
// Reset clears the batch position, the sum, the high slots and all valid bits, and sets the low slots to all ones.
module trimmed_mean_sample_batch #(
  parameter int BATCH_SIZE     = 28,
  parameter int WARMUP_SKIP    = 2,
  parameter int TRIM_EACH_SIDE = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tmsb_pkg::SAMPLE_W-1:0] sample,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic [tmsb_pkg::SAMPLE_W-1:0] mean,
  output logic                          mean_valid,
  input  logic                          mean_ready
);

  localparam int DIVISOR = BATCH_SIZE - WARMUP_SKIP - 2 * TRIM_EACH_SIDE;

  logic                       snap_valid;
  logic                       snap_ready;
  tmsb_pkg::tmsb_snap_t       snap;
  logic                       diff_valid;
  logic                       diff_ready;
  logic [tmsb_pkg::SUM_W-1:0] diff;

  tmsb_accum #(
    .BATCH_SIZE     (BATCH_SIZE),
    .WARMUP_SKIP    (WARMUP_SKIP),
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap)
  );

  tmsb_trim #(
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE),
    .DIVISOR        (DIVISOR)
  ) u_trim (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff       (diff)
  );

  tmsb_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff       (diff),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready),
    .mean       (mean)
  );

endmodule
